// ===== rtl/core/tvbe_pkg.sv =====
// tvbe_pkg: shared types, constants and register map for the tea-variant encryptor
// used by tvbe_mix_unit and tea_variant_block_encrypt
// no dependencies
package tvbe_pkg;

  // cipher constants
  localparam int unsigned ROUNDS_PER_PASS = 24;
  localparam logic [31:0] ROUND_CONST     = 32'h1337_9999;
  localparam int unsigned SHIFT_RIGHT     = 6;
  localparam int unsigned SHIFT_LEFT      = 3;

  // round counter width, at least one bit
  localparam int unsigned RND_W = (ROUNDS_PER_PASS > 1) ? $clog2(ROUNDS_PER_PASS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS_PER_PASS - 1);

  // configuration register map (word index)
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PASS = 3'd4;

  // reset values of the registers
  localparam logic [31:0] KEY0_RST = 32'hFEDC_BABC;
  localparam logic [31:0] KEY1_RST = 32'hCAFE_BABE;
  localparam logic [31:0] KEY2_RST = 32'h1337_9999;
  localparam logic [31:0] KEY3_RST = 32'h4D3C_2B1A;
  localparam logic [7:0]  PASS_RST = 8'd24;

  // payload types
  typedef struct packed {
    logic [31:0] plain_high;
    logic [31:0] plain_low;
  } in_data_t;

  typedef struct packed {
    logic [31:0] cipher_high;
    logic [31:0] cipher_low;
  } out_data_t;

  // operands of one half round
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] acc;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] base;
  } mix_req_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/tvbe_mix_unit.sv =====
// tvbe_mix_unit: shared half-round unit, base + mix(word, acc, key_a, key_b)
// depends on tvbe_pkg
module tvbe_mix_unit
  import tvbe_pkg::*;
(
  input  mix_req_t    req,
  output logic [31:0] result
);

  logic [31:0] term_shr;
  logic [31:0] term_acc;
  logic [31:0] term_shl;

  // three parallel adds, xor, then accumulate into the base word
  always_comb begin
    term_shr = (req.word >> SHIFT_RIGHT) + req.key_a;
    term_acc = req.word + req.acc;
    term_shl = (req.word << SHIFT_LEFT) + req.key_b;
    result   = req.base + (term_shr ^ term_acc ^ term_shl);
  end

endmodule

// ===== rtl/core/tea_variant_block_encrypt.sv =====
// tea_variant_block_encrypt: top level of the tea-variant block encryptor
// depends on tvbe_pkg and tvbe_mix_unit
//
// Encrypts one 64-bit block per transaction with a modified TEA round (shifts 6
// and 3, delta 0x13379999, 24 rounds per pass), repeated pass_count times with
// the round sum restarting at zero each pass. A single mix unit does one half
// round per cycle, two half rounds per round; the finished block then moves to
// the output register once that register is free or being taken (straight
// from idle when pass_count is zero). in_ready is low while a block is in the
// engine; the finished block waits in an output register, so the next block can
// be taken while the previous result is still pending. Keys and pass_count are
// to be written via the APB-style port only while idle; this is not enforced.
module tea_variant_block_encrypt
  import tvbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  in_data_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output out_data_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration registers
  logic [31:0] key0_r, key1_r, key2_r, key3_r;
  logic [7:0]  pass_count_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic        cfg_wr;

  // sequencer and datapath
  state_t      state_r, state_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [RND_W-1:0] round_r, round_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  pass_left_r, pass_left_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_data_t   out_data_r, out_data_nxt;

  logic        in_fire;
  logic        out_fire;
  logic        round_end;
  logic        last_step;
  logic        load_out;
  mix_req_t    mix_req;
  logic [31:0] mix_result;

  // apb decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r       <= KEY0_RST;
      key1_r       <= KEY1_RST;
      key2_r       <= KEY2_RST;
      key3_r       <= KEY3_RST;
      pass_count_r <= PASS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY0: key0_r       <= pwdata;
        REG_KEY1: key1_r       <= pwdata;
        REG_KEY2: key2_r       <= pwdata;
        REG_KEY3: key3_r       <= pwdata;
        REG_PASS: pass_count_r <= pwdata[7:0];
        default:  ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_KEY0: prdata = key0_r;
      REG_KEY1: prdata = key1_r;
      REG_KEY2: prdata = key2_r;
      REG_KEY3: prdata = key3_r;
      REG_PASS: prdata = {24'd0, pass_count_r};
      default:  prdata = '0;
    endcase
  end

  // handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && out_ready;

  assign round_end = phase_r && (round_r == RND_LAST);
  assign last_step = round_end && (pass_left_r == 8'd1);
  assign load_out  = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // shared half-round unit: phase 0 updates lo from hi, phase 1 updates hi from lo
  always_comb begin
    mix_req.acc = acc_r;
    if (!phase_r) begin
      mix_req.word  = hi_r;
      mix_req.key_a = key0_r;
      mix_req.key_b = key1_r;
      mix_req.base  = lo_r;
    end else begin
      mix_req.word  = lo_r;
      mix_req.key_a = key2_r;
      mix_req.key_b = key3_r;
      mix_req.base  = hi_r;
    end
  end

  tvbe_mix_unit u_mix (
    .req    (mix_req),
    .result (mix_result)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (pass_count_r == 8'd0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output updates
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    round_nxt     = round_r;
    phase_nxt     = phase_r;
    pass_left_nxt = pass_left_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_fire;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          lo_nxt        = in_data.plain_low;
          hi_nxt        = in_data.plain_high;
          acc_nxt       = ROUND_CONST;
          round_nxt     = '0;
          phase_nxt     = 1'b0;
          pass_left_nxt = pass_count_r;
        end
      end
      ST_RUN: begin
        if (!phase_r) begin
          lo_nxt = mix_result;
        end else begin
          hi_nxt = mix_result;
        end
        phase_nxt = !phase_r;
        if (phase_r) begin
          if (round_end) begin
            round_nxt     = '0;
            acc_nxt       = ROUND_CONST;
            pass_left_nxt = pass_left_r - 8'd1;
          end else begin
            round_nxt = round_r + RND_W'(1);
            acc_nxt   = acc_r + ROUND_CONST;
          end
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          out_data_nxt.cipher_low  = lo_r;
          out_data_nxt.cipher_high = hi_r;
          out_valid_nxt            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      round_r     <= '0;
      phase_r     <= 1'b0;
      pass_left_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      round_r     <= round_nxt;
      phase_r     <= phase_nxt;
      pass_left_r <= pass_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // a running block always has at least one pass left
  a_pass_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (pass_left_r != 8'd0))
    else $error("engine running with no pass left");

  // the last half round of the last pass hands off to the output stage
  a_last_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && last_step) |=> (state_r == ST_FINISH))
    else $error("last round did not end the block");

  // an accepted transaction keeps the engine busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("engine ready right after accepting a block");

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule

// ===== tb/tb_tea_variant_block_encrypt.sv =====
// tb_tea_variant_block_encrypt: self-checking testbench for the tea-variant block encryptor
// predicts each ciphertext block in place and compares it with every result transaction
// depends on tvbe_pkg and tea_variant_block_encrypt
`timescale 1ns / 1ps

module tb_tea_variant_block_encrypt;
  import tvbe_pkg::*;

  // longest block is 255 passes of 48 half rounds plus the output hand-off
  localparam int unsigned SLOWEST_BLOCK  = 48 * 255 + 1;
  localparam int unsigned WATCHDOG_LIMIT = 5 * SLOWEST_BLOCK + 1000;
  localparam int unsigned PRINT_CAP      = 100;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_data_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_data_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // local copy of the key schedule and pass count
  logic [31:0] key_w0 = KEY0_RST;
  logic [31:0] key_w1 = KEY1_RST;
  logic [31:0] key_w2 = KEY2_RST;
  logic [31:0] key_w3 = KEY3_RST;
  logic [7:0]  pass_total = PASS_RST;

  out_data_t   cipher_queue[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  tea_variant_block_encrypt DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one half round of the modified tea mix
  function automatic logic [31:0] tea_mix(logic [31:0] w, logic [31:0] acc,
                                          logic [31:0] ka, logic [31:0] kb);
    logic [31:0] sr;
    logic [31:0] sl;
    sr = w >> SHIFT_RIGHT;
    sl = w << SHIFT_LEFT;
    return (sr + ka) ^ (w + acc) ^ (sl + kb);
  endfunction

  // full encryption of one block under the current keys and pass count
  function automatic out_data_t encrypt_block(in_data_t blk);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] acc;
    out_data_t   res;
    lo = blk.plain_low;
    hi = blk.plain_high;
    for (int p = 0; p < int'(pass_total); p++) begin
      acc = '0;
      for (int r = 0; r < int'(ROUNDS_PER_PASS); r++) begin
        acc = acc + ROUND_CONST;
        lo  = lo + tea_mix(hi, acc, key_w0, key_w1);
        hi  = hi + tea_mix(lo, acc, key_w2, key_w3);
      end
    end
    res.cipher_low  = lo;
    res.cipher_high = hi;
    return res;
  endfunction

  function automatic in_data_t make_block(logic [31:0] lo, logic [31:0] hi);
    in_data_t blk;
    blk.plain_low  = lo;
    blk.plain_high = hi;
    return blk;
  endfunction

  // word biased toward zero, all ones, single set bits and single clear bits
  function automatic logic [31:0] rand_word();
    logic [31:0] one_hot;
    one_hot = 32'h1 << $urandom_range(31);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (error_count < PRINT_CAP)
      $display("ERROR %0t ns: %s expected %h got %h", $realtime, what, want, got);
    error_count++;
  endtask

  // register write: setup phase, access phase until pready, then an idle phase
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_KEY0: key_w0 = value;
      REG_KEY1: key_w1 = value;
      REG_KEY2: key_w2 = value;
      REG_KEY3: key_w3 = value;
      REG_PASS: pass_total = value[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_keys(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] k3);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
  endtask

  // offer one block and hold it until the transaction completes
  task automatic send_block(in_data_t blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, drain all pending results, then let the engine go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cipher_queue.size() > 0) @(posedge clk);
    repeat (48 * int'(pass_total) + 8) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_block(make_block('0, '0));
    send_block(make_block('1, '1));
    send_block(make_block(32'hAAAA_AAAA, 32'h5555_5555));
    send_block(make_block($urandom, $urandom));
    settle();
  endtask

  task automatic test_pass_through();
    write_reg(REG_PASS, 32'd0);
    send_block(make_block('0, '0));
    send_block(make_block('1, '1));
    send_block(make_block($urandom, $urandom));
    send_block(make_block(32'h8000_0000, 32'h0000_0001));
    settle();
  endtask

  task automatic test_key_extremes();
    write_keys('0, '0, '0, '0);
    write_reg(REG_PASS, 32'd1);
    send_block(make_block('0, '0));
    send_block(make_block('1, '1));
    settle();
    write_keys('1, '1, '1, '1);
    write_reg(REG_PASS, 32'd2);
    send_block(make_block('0, '0));
    send_block(make_block('1, '1));
    settle();
  endtask

  // writes to the unused register slots must leave keys and pass count alone
  task automatic test_spare_index();
    write_keys($urandom, $urandom, $urandom, $urandom);
    write_reg(REG_PASS, 32'd1);
    for (int i = int'(REG_PASS) + 1; i < (1 << REG_IDX_W); i++)
      write_reg(REG_IDX_W'(i), $urandom);
    send_block(make_block($urandom, $urandom));
    send_block(make_block('1, '0));
    settle();
  endtask

  // only the low byte of a pass count write counts
  task automatic test_wide_value();
    write_reg(REG_PASS, 32'hFFFF_FF02);
    send_block(make_block($urandom, $urandom));
    send_block(make_block('0, '1));
    settle();
  endtask

  task automatic test_max_passes();
    write_keys($urandom, $urandom, $urandom, $urandom);
    write_reg(REG_PASS, 32'd255);
    send_block(make_block($urandom, $urandom));
    settle();
    write_reg(REG_PASS, 32'd24);
    send_block(make_block($urandom, $urandom));
    settle();
  endtask

  // random keys and small pass counts, several settings per idling profile
  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned settings, int unsigned per_setting);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < int'(settings); s++) begin
      write_keys(rand_word(), rand_word(), rand_word(), rand_word());
      write_reg(REG_PASS, {16'($urandom_range(16'hFFFF, 0)), 8'h00,
                           8'($urandom_range(4))});
      for (int n = 0; n < int'(per_setting); n++)
        send_block(make_block(rand_word(), rand_word()));
      settle();
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // expected ciphertext for every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      cipher_queue.push_back(encrypt_block(in_data));
  end

  // compare every result transaction with the oldest expectation
  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_queue.size() == 0) begin
        report_mismatch("unexpected result, low word", '0, out_data.cipher_low);
      end else begin
        want = cipher_queue.pop_front();
        if (out_data.cipher_low !== want.cipher_low)
          report_mismatch("cipher_low", want.cipher_low, out_data.cipher_low);
        if (out_data.cipher_high !== want.cipher_high)
          report_mismatch("cipher_high", want.cipher_high, out_data.cipher_high);
      end
    end
  end

  // count cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("ERROR %0t ns: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("tea_variant_block_encrypt: mismatch");
    $finish;
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with light idling
    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_reset_defaults();
    test_pass_through();
    test_key_extremes();
    test_spare_index();
    test_wide_value();
    test_max_passes();

    // random part: receiver idles most, then sender idles most, then neither
    test_random_traffic(30, 74, 3, 116);
    test_random_traffic(74, 30, 3, 116);
    test_random_traffic(0, 0, 3, 116);

    if (error_count == 0) begin
      $display("tea_variant_block_encrypt: match");
    end else begin
      $display("tea_variant_block_encrypt: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tvbe_pkg.sv
rtl/core/tvbe_mix_unit.sv
rtl/core/tea_variant_block_encrypt.sv
tb/tb_tea_variant_block_encrypt.sv
